FILE: src/per_source_duplicate_filter_top_macros.svh
// assertion helpers for the top rtl file
// all checks run on clock and are held off while reset is high
`ifndef PER_SOURCE_DUPLICATE_FILTER_TOP_MACROS_SVH
`define PER_SOURCE_DUPLICATE_FILTER_TOP_MACROS_SVH

// same-cycle implication
`define PSDF_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("psdf same-cycle check failed");

// next-cycle implication
`define PSDF_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("psdf next-cycle check failed");

`endif

FILE: src/psdf_pkg.sv
`timescale 1ns / 1ps
package psdf_pkg;

   // fixed field widths of the request word
   localparam int ADDR_W    = 48;
   localparam int SEQ_NUM_W = 12;

   // per-entry write controls
   typedef struct packed {
      logic alloc;   // store a new source in this entry
      logic update;  // overwrite the stored sequence number
   } entry_ctl_type;

   // per-entry compare status
   typedef struct packed {
      logic hit;     // valid entry holding the request address
      logic dup;     // hit with the same sequence number
   } entry_stat_type;

endpackage

FILE: src/psdf_entry.sv
`timescale 1ns / 1ps
module psdf_entry #(
   parameter int SEQ_W = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  psdf_pkg::entry_ctl_type       ctl,
   input  logic [psdf_pkg::ADDR_W-1:0]   addr,
   input  logic [SEQ_W-1:0]              seq,
   output psdf_pkg::entry_stat_type      stat
);
   import psdf_pkg::*;

   logic              valid_ff;
   logic              valid_in;
   logic [ADDR_W-1:0] addr_ff;
   logic [SEQ_W-1:0]  seq_ff;

   assign valid_in = valid_ff | ctl.alloc;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (ctl.alloc) begin
         addr_ff <= addr;
      end
      if (ctl.alloc || ctl.update) begin
         seq_ff <= seq;
      end
   end

   always_comb begin
      stat.hit = valid_ff && (addr_ff == addr);
      stat.dup = stat.hit && (seq_ff == seq);
   end

endmodule

FILE: src/psdf_alloc.sv
`timescale 1ns / 1ps
module psdf_alloc #(
   parameter int NUM_SOURCES = 16,
   parameter int USED_W      = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              grant,
   output logic [USED_W-1:0] used,
   output logic              full
);

   logic [USED_W-1:0] used_ff;
   logic [USED_W-1:0] used_in;

   assign used_in = grant ? (used_ff + 1'b1) : used_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

   assign used = used_ff;
   assign full = (used_ff == USED_W'(NUM_SOURCES));

endmodule

FILE: src/per_source_duplicate_filter_top.sv
`timescale 1ns / 1ps
// per-source duplicate filter: each request word carries a transmitter address
// and a sequence number; exactly one response word comes back for each request
// taken (start high and busy low), via the input and result registers, marked by
// rsp_valid for one cycle, and the receiver cannot stall it. busy is low whenever
// reset is low, so a new request can be taken every cycle; throughput is one
// word per clock, set by the parallel compare of the request address against
// all NUM_SOURCES table entries. requests are handled strictly in order and
// each one sees the table as left by the one before. the table fills from entry
// 0 and entries are never freed; once all entries are in use, unknown sources
// are delivered with rsp_new_source and rsp_table_full set
module per_source_duplicate_filter_top #(
   parameter int NUM_SOURCES = 16,
   parameter int SEQ_BITS    = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [psdf_pkg::ADDR_W-1:0]           req_transmitter_address,
   input  logic [psdf_pkg::SEQ_NUM_W-1:0]        req_seq_num,
   output logic                                  rsp_valid,
   output logic                                  rsp_deliver,
   output logic                                  rsp_new_source,
   output logic                                  rsp_table_full
);
   import psdf_pkg::*;

   // only the low SEQ_BITS of the sequence field take part, capped at the field
   localparam int SEQ_W  = (SEQ_BITS < SEQ_NUM_W) ? SEQ_BITS : SEQ_NUM_W;
   localparam int USED_W = $clog2(NUM_SOURCES + 1);

   // input register
   logic              req_vld_ff;
   logic [ADDR_W-1:0] req_addr_ff;
   logic [SEQ_W-1:0]  req_seq_ff;

   // result register
   logic rsp_valid_ff;
   logic rsp_deliver_ff;
   logic rsp_new_source_ff;
   logic rsp_table_full_ff;
   logic rsp_deliver_in;
   logic rsp_new_source_in;
   logic rsp_table_full_in;

   // table status
   entry_ctl_type    ctl_vec  [NUM_SOURCES];
   entry_stat_type   stat_vec [NUM_SOURCES];
   logic [NUM_SOURCES-1:0] hit_vec;
   logic [NUM_SOURCES-1:0] dup_vec;
   logic              any_hit;
   logic              any_dup;
   logic              grant;
   logic [USED_W-1:0] used;
   logic              full;

   // no internal backpressure, only held off while in reset
   assign busy = reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_addr_ff <= req_transmitter_address;
         req_seq_ff  <= req_seq_num[SEQ_W-1:0];
      end
   end

   // one compare cell per table entry
   for (genvar i = 0; i < NUM_SOURCES; i++) begin : g_entry
      // a new source goes to the next free entry, a hit refreshes its number
      assign ctl_vec[i].alloc  = grant && (used == USED_W'(i));
      assign ctl_vec[i].update = req_vld_ff && stat_vec[i].hit;
      assign hit_vec[i]        = stat_vec[i].hit;
      assign dup_vec[i]        = stat_vec[i].dup;

      psdf_entry #(
         .SEQ_W (SEQ_W)
      ) u_entry (
         .clock (clock),
         .reset (reset),
         .ctl   (ctl_vec[i]),
         .addr  (req_addr_ff),
         .seq   (req_seq_ff),
         .stat  (stat_vec[i])
      );
   end

   // sources are stored at most once, so at most one entry can hit
   assign any_hit = |hit_vec;
   assign any_dup = |dup_vec;

   // store a new source only while a free entry remains
   assign grant = req_vld_ff && !any_hit && !full;

   psdf_alloc #(
      .NUM_SOURCES (NUM_SOURCES),
      .USED_W      (USED_W)
   ) u_alloc (
      .clock (clock),
      .reset (reset),
      .grant (grant),
      .used  (used),
      .full  (full)
   );

   // verdict for the word in the input register
   assign rsp_deliver_in    = !any_dup;
   assign rsp_new_source_in = !any_hit;
   assign rsp_table_full_in = !any_hit && full;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_deliver_ff    <= rsp_deliver_in;
      rsp_new_source_ff <= rsp_new_source_in;
      rsp_table_full_ff <= rsp_table_full_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_deliver    = rsp_deliver_ff;
   assign rsp_new_source = rsp_new_source_ff;
   assign rsp_table_full = rsp_table_full_ff;

`include "per_source_duplicate_filter_top_macros.svh"

   // a source never sits in two entries
   `PSDF_ASSERT_IMP(a_hit_unique, 1'b1, $onehot0(hit_vec))
   // every word in the input register leads to a valid response word
   `PSDF_ASSERT_NXT(a_rsp_follows, req_vld_ff, rsp_valid_ff)
   // a stored new source moved the fill count by exactly one
   `PSDF_ASSERT_IMP(a_fill_step,
      rsp_valid_ff && rsp_new_source_ff && !rsp_table_full_ff,
      used == ($past(used) + 1'b1))
   // a full flag only once every entry is in use
   `PSDF_ASSERT_IMP(a_full_flag, rsp_valid_ff && rsp_table_full_ff,
      used == USED_W'(NUM_SOURCES))
   // fill count never passes the table size
   `PSDF_ASSERT_IMP(a_used_range, 1'b1, used <= USED_W'(NUM_SOURCES))

endmodule

FILE: verif/tb_per_source_duplicate_filter_top.sv
`timescale 1ns / 1ps

// one expected response word
typedef struct packed {
   logic deliver;
   logic new_source;
   logic table_full;
} verdict_type;

// shadow source table plus the verdicts still owed by the block
class source_table_tracker #(int DEPTH = 16, int SEQW = 12);
   bit                              src_valid[DEPTH];
   logic [psdf_pkg::ADDR_W-1:0]     src_addr[DEPTH];
   logic [psdf_pkg::SEQ_NUM_W-1:0]  src_seq[DEPTH];
   int unsigned                     used;
   verdict_type                     pending_verdicts[$];
   int unsigned                     errors;

   function new();
      foreach (src_valid[i]) src_valid[i] = 1'b0;
      used   = 0;
      errors = 0;
   endfunction

   // work out the verdict for a taken frame and advance the shadow table
   function void record_frame(logic [psdf_pkg::ADDR_W-1:0] addr,
                              logic [psdf_pkg::SEQ_NUM_W-1:0] seq_raw);
      logic [psdf_pkg::SEQ_NUM_W-1:0] seq_mask;
      logic [psdf_pkg::SEQ_NUM_W-1:0] seq;
      int                             hit;
      verdict_type                    v;
      seq_mask = psdf_pkg::SEQ_NUM_W'((64'd1 << SEQW) - 64'd1);
      seq      = seq_raw & seq_mask;
      hit      = -1;
      v        = '{deliver: 1'b1, new_source: 1'b0, table_full: 1'b0};
      for (int i = 0; i < DEPTH; i++) begin
         if (hit < 0 && src_valid[i] && src_addr[i] == addr) hit = i;
      end
      if (hit < 0) begin
         v.new_source = 1'b1;
         if (used < DEPTH) begin
            src_valid[used] = 1'b1;
            src_addr[used]  = addr;
            src_seq[used]   = seq;
            used++;
         end else begin
            v.table_full = 1'b1;
         end
      end else if (src_seq[hit] != seq) begin
         src_seq[hit] = seq;
      end else begin
         v.deliver = 1'b0;
      end
      pending_verdicts.push_back(v);
   endfunction

   // compare one response word against the oldest owed verdict
   function void check_verdict(logic deliver, logic new_source, logic table_full);
      verdict_type v;
      if (pending_verdicts.size() == 0) begin
         $display("%0t: response word with none expected (deliver %b new %b full %b)",
                  $time, deliver, new_source, table_full);
         errors++;
         return;
      end
      v = pending_verdicts.pop_front();
      if (deliver !== v.deliver) begin
         $display("%0t: deliver expected %b actual %b", $time, v.deliver, deliver);
         errors++;
      end
      if (new_source !== v.new_source) begin
         $display("%0t: new_source expected %b actual %b", $time, v.new_source,
                  new_source);
         errors++;
      end
      if (table_full !== v.table_full) begin
         $display("%0t: table_full expected %b actual %b", $time, v.table_full,
                  table_full);
         errors++;
      end
   endfunction

   function int unsigned outstanding();
      return pending_verdicts.size();
   endfunction
endclass

module tb_per_source_duplicate_filter_top;

   localparam int TABLE_DEPTH  = 16;
   localparam int SEQ_WIDTH    = 12;
   localparam int RANDOM_WORDS = 750;
   // the limit leaves wide margin over the slowest legal run
   localparam int CYCLE_LIMIT  = 200000;

   typedef source_table_tracker #(TABLE_DEPTH, SEQ_WIDTH) tracker_type;

   logic                            clock;
   logic                            reset;
   logic                            start;
   logic                            busy;
   logic [psdf_pkg::ADDR_W-1:0]     req_transmitter_address;
   logic [psdf_pkg::SEQ_NUM_W-1:0]  req_seq_num;
   logic                            rsp_valid;
   logic                            rsp_deliver;
   logic                            rsp_new_source;
   logic                            rsp_table_full;

   int unsigned cycle_count;

   // addresses known to sit in the table and the last number sent for each
   logic [psdf_pkg::ADDR_W-1:0]     known_addr[TABLE_DEPTH];
   logic [psdf_pkg::SEQ_NUM_W-1:0]  known_seq[TABLE_DEPTH];

   tracker_type tracker = new();

   per_source_duplicate_filter_top #(
      .NUM_SOURCES(TABLE_DEPTH),
      .SEQ_BITS   (SEQ_WIDTH)
   ) dut (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_transmitter_address(req_transmitter_address),
      .req_seq_num            (req_seq_num),
      .rsp_valid              (rsp_valid),
      .rsp_deliver            (rsp_deliver),
      .rsp_new_source         (rsp_new_source),
      .rsp_table_full         (rsp_table_full)
   );

   // 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // watchdog: a cycle counter that ends a hung run
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   // monitor: values seen here are the ones from before the edge, since all
   // driving is nonblocking; a request word is noted before the response is
   // checked so the ordering inside one edge never matters
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) tracker.record_frame(req_transmitter_address, req_seq_num);
         if (rsp_valid) tracker.check_verdict(rsp_deliver, rsp_new_source, rsp_table_full);
      end
   end

   // present one request word and hold it until it is taken; an optional
   // random gap of idle cycles comes first, with junk on the fields
   task automatic send_frame(input logic [psdf_pkg::ADDR_W-1:0] addr,
                             input logic [psdf_pkg::SEQ_NUM_W-1:0] seq,
                             input bit gaps_on);
      logic [63:0] junk;
      if (gaps_on && $urandom_range(99) < 27) begin
         junk = {$urandom, $urandom};
         start                   <= 1'b0;
         req_transmitter_address <= junk[47:0];
         req_seq_num             <= junk[59:48];
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      start                   <= 1'b1;
      req_transmitter_address <= addr;
      req_seq_num             <= seq;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // hold the sender off until every owed verdict has come back; start drops
   // first so the last word is not taken again while waiting
   task automatic wait_until_drained();
      start <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
   endtask

   initial begin
      int unsigned                     pick;
      int unsigned                     idx;
      int unsigned                     shift_list[14];
      logic [63:0]                     wide;
      logic [psdf_pkg::ADDR_W-1:0]     addr;
      logic [psdf_pkg::SEQ_NUM_W-1:0]  seq;
      bit                              gaps_on;

      shift_list = '{0, 1, 7, 11, 15, 19, 23, 27, 31, 35, 39, 43, 46, 47};

      start                   <= 1'b0;
      req_transmitter_address <= '0;
      req_seq_num             <= '0;
      reset                   <= 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // directed: zero address with both number extremes, new then duplicate then
      // update then duplicate
      send_frame(48'h0, 12'h000, 1'b1);
      send_frame(48'h0, 12'h000, 1'b1);
      send_frame(48'h0, 12'hFFF, 1'b1);
      send_frame(48'h0, 12'hFFF, 1'b1);
      known_addr[0] = 48'h0;
      known_seq[0]  = 12'hFFF;

      // all-ones address
      send_frame(48'hFFFF_FFFF_FFFF, 12'hFFF, 1'b1);
      send_frame(48'hFFFF_FFFF_FFFF, 12'hFFF, 1'b1);
      send_frame(48'hFFFF_FFFF_FFFF, 12'h000, 1'b1);
      known_addr[1] = 48'hFFFF_FFFF_FFFF;
      known_seq[1]  = 12'h000;

      // fill the rest with single-bit addresses, each one bit away from the
      // zero entry, with the set bits spread from bit 0 to bit 47 of the address
      for (int k = 0; k < 14; k++) begin
         addr = 48'h1 << shift_list[k];
         seq  = (k == 13) ? 12'hABC : 12'(1 << (k % 12));
         send_frame(addr, seq, 1'b1);
         known_addr[k + 2] = addr;
         known_seq[k + 2]  = seq;
      end

      // table now full: unknown source flagged twice, since it is never stored
      send_frame(48'hFFFF_FFFF_FFFE, 12'h000, 1'b1);
      send_frame(48'hFFFF_FFFF_FFFE, 12'h000, 1'b1);

      // last entry still matches: duplicate, then update
      send_frame(48'h8000_0000_0000, 12'hABC, 1'b1);
      send_frame(48'h8000_0000_0000, 12'h543, 1'b1);
      known_seq[15] = 12'h543;

      // random part: mostly frames from known sources, half of them repeats
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         // long stretch with back-to-back request words
         gaps_on = !(n >= 200 && n < 350);
         // sender holds off once until the pipe is empty
         if (n == 400) wait_until_drained();

         pick = $urandom_range(99);
         wide = {$urandom, $urandom};
         idx  = $urandom_range(TABLE_DEPTH - 1);
         if (pick < 70) begin
            addr = known_addr[idx];
            case ($urandom_range(3))
               0, 1: seq = known_seq[idx];
               2: seq = known_seq[idx] ^ (12'h1 << $urandom_range(SEQ_WIDTH - 1));
               default: seq = wide[59:48];
            endcase
            known_seq[idx] = seq;
         end else if (pick < 85) begin
            // near miss: known address with one bit flipped
            addr = known_addr[idx] ^ (48'h1 << $urandom_range(psdf_pkg::ADDR_W - 1));
            seq  = wide[59:48];
         end else begin
            addr = wide[47:0];
            seq  = wide[59:48];
         end
         send_frame(addr, seq, gaps_on);
      end

      wait_until_drained();
      // leave idle clocks after the last response so a stray word would be caught
      repeat (6) @(posedge clock);

      if (tracker.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
